@@ hdl/stl_pkg.sv @@
package stl_pkg;

   localparam int MAX_KEYWORD_CHARS_DEFAULT = 8;
   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH = 4;

   // token kind codes
   localparam logic [6:0] K_CHAR_QUOTE = 7'd3;
   localparam logic [6:0] K_STR_QUOTE = 7'd4;
   localparam logic [6:0] K_NUMBER = 7'd0;
   localparam logic [6:0] K_BOOLEAN = 7'd5;
   localparam logic [6:0] K_INVALID = 7'd8;
   localparam logic [6:0] K_IDENT = 7'd28;
   localparam logic [6:0] K_ASSIGN = 7'd29;
   localparam logic [6:0] K_HASH = 7'd30;
   localparam logic [6:0] K_AT = 7'd31;
   localparam logic [6:0] K_SHEBANG = 7'd32;
   localparam logic [6:0] K_SEMI = 7'd34;
   localparam logic [6:0] K_LPAREN = 7'd35;
   localparam logic [6:0] K_RPAREN = 7'd36;
   localparam logic [6:0] K_LBRACKET = 7'd37;
   localparam logic [6:0] K_RBRACKET = 7'd38;
   localparam logic [6:0] K_LBRACE = 7'd39;
   localparam logic [6:0] K_RBRACE = 7'd40;
   localparam logic [6:0] K_GT = 7'd41;
   localparam logic [6:0] K_LT = 7'd42;
   localparam logic [6:0] K_GE = 7'd43;
   localparam logic [6:0] K_LE = 7'd44;
   localparam logic [6:0] K_EQ = 7'd45;
   localparam logic [6:0] K_PLUS = 7'd60;
   localparam logic [6:0] K_MINUS = 7'd61;
   localparam logic [6:0] K_STAR = 7'd62;
   localparam logic [6:0] K_SLASH = 7'd63;
   localparam logic [6:0] K_COMMENT = 7'd64;
   localparam logic [6:0] K_CARET = 7'd65;
   localparam logic [6:0] K_BANG = 7'd66;
   localparam logic [6:0] K_PERCENT = 7'd69;
   localparam logic [6:0] K_EOF = 7'd74;
   localparam logic [6:0] K_LAST = 7'd81;

   localparam logic [15:0] LEN_MAX = 16'hFFFF;
   localparam logic [23:0] POS24_MAX = 24'hFFFFFF;

   localparam int KW_COUNT = 39;
   localparam int KW_MAX_LEN = 8;

   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "init", "uninit", "var", "int", "uint", "boolean", "str", "char", "void", "out",
      "stdout", "errout", "stderr", "outstack", "include", "vmem", "stack", "heap",
      "allocate", "free", "run", "exec", "forward", "boot", "ignite", "fail",
      "exit", "fnc", "ret", "break", "continue", "if", "else", "for", "while",
      "true", "false", "ptr", "dref"};

   localparam int KW_LEN [KW_COUNT] = '{
      4, 6, 3, 3, 4, 7, 3, 4, 4, 3, 6, 6, 6, 8, 7, 4, 5, 4, 8, 4, 3, 4, 7, 4, 6, 4,
      4, 3, 3, 5, 8, 2, 4, 3, 5, 4, 5, 3, 4};

   localparam logic [6:0] KW_KIND [KW_COUNT] = '{
      7'd9, 7'd10, 7'd11, 7'd12, 7'd18, 7'd27, 7'd26, 7'd25, 7'd24, 7'd54,
      7'd55, 7'd56, 7'd57, 7'd73, 7'd33, 7'd49, 7'd50, 7'd51, 7'd52, 7'd53,
      7'd47, 7'd48, 7'd70, 7'd71, 7'd72, 7'd58, 7'd59, 7'd46, 7'd81, 7'd79,
      7'd80, 7'd75, 7'd76, 7'd77, 7'd78, K_BOOLEAN, K_BOOLEAN, 7'd67, 7'd68};

   // packed so that the kind sits in the lowest bits
   typedef struct packed {
      logic [31:0] token_index;
      logic [23:0] column_number;
      logic [23:0] line_number;
      logic [15:0] token_length;
      logic [31:0] start_offset;
      logic [6:0]  token_kind;
   } token_type;

   typedef struct packed {
      token_type tok;
      logic      last_of_run;
   } entry_type;

   typedef struct packed {
      logic [1:0] count;
      entry_type  entry0;
      entry_type  entry1;
   } push_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_opener(input logic [7:0] c);
      return c == "=" || c == ">" || c == "<" || c == "#" || c == "/";
   endfunction

   function automatic logic [6:0] single_kind(input logic [7:0] c);
      logic [6:0] k;
      case (c)
         "=": k = K_ASSIGN;
         "#": k = K_HASH;
         "@": k = K_AT;
         "(": k = K_LPAREN;
         ")": k = K_RPAREN;
         "[": k = K_LBRACKET;
         "]": k = K_RBRACKET;
         "{": k = K_LBRACE;
         "}": k = K_RBRACE;
         ";": k = K_SEMI;
         "-": k = K_MINUS;
         "+": k = K_PLUS;
         "*": k = K_STAR;
         "/": k = K_SLASH;
         "%": k = K_PERCENT;
         "<": k = K_LT;
         ">": k = K_GT;
         "^": k = K_CARET;
         "!": k = K_BANG;
         8'h27: k = K_CHAR_QUOTE;
         8'h22: k = K_STR_QUOTE;
         default: k = K_INVALID;
      endcase
      return k;
   endfunction

   // zero when the two bytes form no operator
   function automatic logic [6:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
      logic [6:0] k;
      k = '0;
      if (a == "=" && b == "=") k = K_EQ;
      if (a == ">" && b == "=") k = K_GE;
      if (a == "<" && b == "=") k = K_LE;
      if (a == "#" && b == "!") k = K_SHEBANG;
      if (a == "/" && b == "/") k = K_COMMENT;
      return k;
   endfunction

   // first character moves to the lowest byte
   function automatic logic [63:0] byte_rev(input logic [63:0] s, input int n);
      logic [63:0] r;
      r = '0;
      for (int j = 0; j < 8; j++) begin
         if (j < n) r[8*j +: 8] = s[8*(n-1-j) +: 8];
      end
      return r;
   endfunction

   // chars are zero padded above the word, so the text alone fixes the length
   function automatic logic [6:0] word_kind(input logic [63:0] chars);
      logic [6:0] k;
      k = K_IDENT;
      for (int i = 0; i < KW_COUNT; i++) begin
         if (chars == byte_rev(KW_TEXT[i], KW_LEN[i])) k = KW_KIND[i];
      end
      return k;
   endfunction

endpackage

@@ hdl/stl_queue.sv @@
module stl_queue (
   input  logic                clock,
   input  logic                reset,
   input  stl_pkg::push_type   push,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output stl_pkg::entry_type  out_entry
);

   localparam int PTR_BITS = $clog2(stl_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(stl_pkg::QUEUE_DEPTH + 1);

   stl_pkg::entry_type mem_ff [stl_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic pop;

   assign out_valid = count_ff != '0;
   assign out_entry = mem_ff[rd_ptr_ff];
   assign pop = out_valid && out_ready;
   // two free slots so that any request can land
   assign room = count_ff <= CNT_BITS'(stl_pkg::QUEUE_DEPTH - 2);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
      count_in = count_ff + CNT_BITS'(push.count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.entry0;
      if (push.count == 2'd2) mem_ff[wr_ptr_ff + PTR_BITS'(1)] <= push.entry1;
   end

endmodule

@@ hdl/stl_scan.sv @@
module stl_scan #(
   parameter int MAX_KEYWORD_CHARS = stl_pkg::MAX_KEYWORD_CHARS_DEFAULT,
   parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              end_of_source,
   input  logic [7:0]        ch,
   output stl_pkg::push_type push
);

   typedef enum logic [1:0] {MODE_IDLE, MODE_WORD, MODE_NUM, MODE_PEND} mode_type;

   localparam logic [POSITION_BITS-1:0] OFFSET_MAX = '1;

   mode_type mode_ff, mode_in;
   logic [MAX_KEYWORD_CHARS-1:0][7:0] word_ff, word_in;
   logic [15:0] run_length_ff, run_length_in;
   logic [POSITION_BITS-1:0] run_start_ff, run_start_in;
   logic [23:0] run_line_ff, run_line_in;
   logic [23:0] run_column_ff, run_column_in;
   logic [POSITION_BITS-1:0] cur_offset_ff, cur_offset_in;
   logic [23:0] cur_line_ff, cur_line_in;
   logic [23:0] cur_column_ff, cur_column_in;
   logic [31:0] emitted_ff, emitted_in;

   stl_pkg::token_type flush_tok, tok_a, tok_b;
   logic a_valid, b_valid, idle_path;
   logic [6:0] flush_kind, pk;

   always_comb begin
      case (mode_ff)
         MODE_WORD: flush_kind = (run_length_ff <= 16'(stl_pkg::KW_MAX_LEN))
                                 ? stl_pkg::word_kind(word_ff[7:0]) : stl_pkg::K_IDENT;
         MODE_NUM: flush_kind = stl_pkg::K_NUMBER;
         MODE_PEND: flush_kind = stl_pkg::single_kind(word_ff[0]);
         default: flush_kind = stl_pkg::K_INVALID;
      endcase
      flush_tok = '0;
      flush_tok.token_kind = flush_kind;
      flush_tok.start_offset = 32'(run_start_ff);
      flush_tok.token_length = run_length_ff;
      flush_tok.line_number = run_line_ff;
      flush_tok.column_number = run_column_ff;
   end

   always_comb begin
      mode_in = mode_ff;
      word_in = word_ff;
      run_length_in = run_length_ff;
      run_start_in = run_start_ff;
      run_line_in = run_line_ff;
      run_column_in = run_column_ff;
      cur_offset_in = cur_offset_ff;
      cur_line_in = cur_line_ff;
      cur_column_in = cur_column_ff;
      emitted_in = emitted_ff;
      a_valid = 1'b0;
      b_valid = 1'b0;
      idle_path = 1'b0;
      tok_a = flush_tok;
      tok_b = '0;
      tok_b.start_offset = 32'(cur_offset_ff);
      tok_b.line_number = cur_line_ff;
      tok_b.column_number = cur_column_ff;
      pk = stl_pkg::pair_kind(word_ff[0], ch);

      if (fire && end_of_source) begin
         a_valid = mode_ff != MODE_IDLE;
         b_valid = 1'b1;
         tok_b.token_kind = stl_pkg::K_EOF;
         tok_b.token_length = '0;
         mode_in = MODE_IDLE;
         word_in = '0;
         run_length_in = '0;
         run_start_in = '0;
         run_line_in = 24'd1;
         run_column_in = 24'd1;
         cur_offset_in = '0;
         cur_line_in = 24'd1;
         cur_column_in = 24'd1;
      end else if (fire) begin
         // every byte moves the position once
         if (cur_offset_ff != OFFSET_MAX) cur_offset_in = cur_offset_ff + 1'b1;
         if (ch == 8'h0A) begin
            if (cur_line_ff != stl_pkg::POS24_MAX) cur_line_in = cur_line_ff + 1'b1;
            cur_column_in = 24'd1;
         end else if (cur_column_ff != stl_pkg::POS24_MAX) begin
            cur_column_in = cur_column_ff + 1'b1;
         end

         case (mode_ff)
            MODE_WORD: begin
               if (stl_pkg::is_alpha(ch) || stl_pkg::is_digit(ch)) begin
                  for (int j = 0; j < MAX_KEYWORD_CHARS; j++) begin
                     if (run_length_ff == 16'(j)) word_in[j] = ch;
                  end
                  if (run_length_ff != stl_pkg::LEN_MAX) run_length_in = run_length_ff + 1'b1;
               end else begin
                  a_valid = 1'b1;
                  idle_path = 1'b1;
               end
            end
            MODE_NUM: begin
               if (stl_pkg::is_digit(ch)) begin
                  for (int j = 0; j < MAX_KEYWORD_CHARS; j++) begin
                     if (run_length_ff == 16'(j)) word_in[j] = ch;
                  end
                  if (run_length_ff != stl_pkg::LEN_MAX) run_length_in = run_length_ff + 1'b1;
               end else begin
                  a_valid = 1'b1;
                  idle_path = 1'b1;
               end
            end
            MODE_PEND: begin
               a_valid = 1'b1;
               if (pk != '0) begin
                  tok_a.token_kind = pk;
                  tok_a.token_length = 16'd2;
                  mode_in = MODE_IDLE;
               end else begin
                  idle_path = 1'b1;
               end
            end
            default: idle_path = 1'b1;
         endcase

         if (idle_path) begin
            mode_in = MODE_IDLE;
            if (stl_pkg::is_space(ch)) begin
               mode_in = MODE_IDLE;
            end else if (stl_pkg::is_alpha(ch) || stl_pkg::is_digit(ch)
                         || stl_pkg::is_opener(ch)) begin
               if (stl_pkg::is_alpha(ch)) mode_in = MODE_WORD;
               else if (stl_pkg::is_digit(ch)) mode_in = MODE_NUM;
               else mode_in = MODE_PEND;
               word_in = '0;
               word_in[0] = ch;
               run_length_in = 16'd1;
               run_start_in = cur_offset_ff;
               run_line_in = cur_line_ff;
               run_column_in = cur_column_ff;
            end else begin
               b_valid = 1'b1;
               tok_b.token_kind = stl_pkg::single_kind(ch);
               tok_b.token_length = 16'd1;
            end
         end
      end

      // pack the tokens into the queue slots
      push = '0;
      push.count = 2'(a_valid) + 2'(b_valid);
      push.entry0.tok = a_valid ? tok_a : tok_b;
      push.entry0.tok.token_index = emitted_ff;
      push.entry0.last_of_run = push.count == 2'd1;
      push.entry1.tok = tok_b;
      push.entry1.tok.token_index = emitted_ff + 32'd1;
      push.entry1.last_of_run = 1'b1;
      if (fire) begin
         emitted_in = end_of_source ? '0 : emitted_ff + 32'(push.count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         word_ff <= '0;
         run_length_ff <= '0;
         run_start_ff <= '0;
         run_line_ff <= 24'd1;
         run_column_ff <= 24'd1;
         cur_offset_ff <= '0;
         cur_line_ff <= 24'd1;
         cur_column_ff <= 24'd1;
         emitted_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         word_ff <= word_in;
         run_length_ff <= run_length_in;
         run_start_ff <= run_start_in;
         run_line_ff <= run_line_in;
         run_column_ff <= run_column_in;
         cur_offset_ff <= cur_offset_in;
         cur_line_ff <= cur_line_in;
         cur_column_ff <= cur_column_in;
         emitted_ff <= emitted_in;
      end
   end

endmodule

@@ hdl/source_token_lexer_unit.sv @@
// Streaming tokenizer: one source byte per request in, tokens out.
// Request channel: req_tdata carries the byte, req_tuser = 1 marks end of
// source (the byte is then ignored). Response channel: one token per
// transfer on rsp_tdata; rsp_tlast is high on the final token caused by a
// request. A request gives zero, one or two tokens; end of source always
// gives an EOF token and then returns the position, line, column and token
// count to their start values.
// A request is registered in the input register, scanned once the token
// queue has room, and its tokens wait in the queue for the receiver.
// Throughput: one request per cycle while the queue has room. The scanner
// fires only while the four-entry token queue has two free slots, and the
// queue drains one token per cycle while the receiver is ready, so runs of
// requests that each give two tokens are held back to that drain rate.
// When the receiver stalls, tokens wait in the queue, then the input
// register fills and req_tready drops. Reset (synchronous) empties the
// queue and the input register and puts the scanner at offset 0, line 1,
// column 1, token index 0.
module source_token_lexer_unit #(
   parameter int MAX_KEYWORD_CHARS = stl_pkg::MAX_KEYWORD_CHARS_DEFAULT,
   parameter int POSITION_BITS = stl_pkg::POSITION_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] ch
   input  logic         req_tuser,   // [0] kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [6:0] token_kind, [38:7] start_offset, [54:39] token_length,
   // [78:55] line_number, [102:79] column_number, [134:103] token_index
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast    // last_of_run
);

   logic in_valid_ff, in_valid_in;
   logic in_eos_ff;
   logic [7:0] in_ch_ff;
   logic room, fire;
   stl_pkg::push_type push;
   stl_pkg::entry_type out_entry;

   assign fire = in_valid_ff && room;
   assign req_tready = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_ch_ff <= req_tdata;
         in_eos_ff <= req_tuser;
      end
   end

   stl_scan #(
      .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS),
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .end_of_source(in_eos_ff),
      .ch(in_ch_ff),
      .push(push)
   );

   stl_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .room(room),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_entry(out_entry)
   );

   assign rsp_tdata = {1'b0, out_entry.tok};
   assign rsp_tlast = out_entry.last_of_run;

endmodule

@@ hdl/stl_checker.sv @@
module stl_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic         rsp_tlast
);

   logic [6:0] kind;
   logic [15:0] length;

   assign kind = rsp_tdata[6:0];
   assign length = rsp_tdata[54:39];

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response offered after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // end of source always closes the run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind == stl_pkg::K_EOF |-> rsp_tlast && length == 16'd0)
      else $error("eof token not last or not empty");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> kind <= stl_pkg::K_LAST)
      else $error("token kind out of range");

   a_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kind != stl_pkg::K_EOF |-> length != 16'd0)
      else $error("empty token other than eof");

endmodule

bind source_token_lexer_unit stl_checker u_stl_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
